>>> hw/rtl/vgs_pkg.sv
// vgs_pkg: shared types and constants for the voxel grid store
// no dependencies; imported by vgs_axis, voxel_grid_store and vgs_checker
`default_nettype none

package vgs_pkg;

  // store geometry, fixed by the 12-bit cell index
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CFG_IDX_W   = 3;

  // value of an empty or out-of-bounds cell
  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z = 3'd5;

  // access modes
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_IDX   = 5'b01000,
    ST_RESP  = 5'b10000
  } vgs_state_e;

  // stage enables from the sequencer to the axis lanes
  typedef struct packed {
    logic sub_en;
    logic mul_en;
  } axis_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/vgs_ram.sv
// vgs_ram: generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module vgs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/vgs_axis.sv
// vgs_axis: one axis lane, position to cell coordinate
// subtract grid minimum, multiply by scale, floor and bounds check; uses vgs_pkg
`default_nettype none

module vgs_axis #(
  parameter int unsigned COUNT = 16
) (
  input  wire logic                       clk_i,
  input  wire vgs_pkg::axis_ctl_t         ctl_i,
  input  wire logic signed [31:0]         pos_i,
  input  wire logic signed [31:0]         min_i,
  input  wire logic        [31:0]         scale_i,
  output logic                            ok_o,
  output logic             [$clog2(COUNT)-1:0] cell_o
);

  import vgs_pkg::*;

  localparam int unsigned CW = $clog2(COUNT);

  logic [32:0] diff;
  logic        neg_q, neg2_q;
  logic [31:0] mag_q;
  logic [63:0] prod;
  logic [31:0] hi_q;

  // exact 33-bit difference
  assign diff = {pos_i[31], pos_i} - {min_i[31], min_i};

  always_ff @(posedge clk_i) begin
    if (ctl_i.sub_en) begin
      neg_q <= diff[32];
      mag_q <= diff[31:0];
    end
  end

  // q32.32 product, integer part kept
  assign prod = 64'(mag_q) * 64'(scale_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      neg2_q <= neg_q;
      hi_q   <= prod[63:32];
    end
  end

  // negative offset is only in range when the scale is zero
  assign ok_o   = neg2_q ? (scale_i == 32'd0) : (hi_q < 32'(COUNT));
  assign cell_o = neg2_q ? '0 : hi_q[CW-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/voxel_grid_store.sv
// voxel_grid_store: top level, config registers, sequencer and voxel ram
// uses vgs_pkg, vgs_axis and vgs_ram
`default_nettype none

// Voxel store addressed by a signed Q16.16 position. An item is accepted when
// start is high and busy is low; after the subtract, multiply, index and ram
// access, and ram read steps its result appears on done_o for one cycle, with
// busy low again, so a new item is taken only once the last result is out.
// Results cannot be held off. After reset the block clears all 4096 ram
// entries to -1, one per cycle, and holds busy high until the clear is done.
// The user must write configuration only while idle; the block does not enforce it.
module voxel_grid_store #(
  parameter int unsigned GRID_X = 16,
  parameter int unsigned GRID_Y = 16,
  parameter int unsigned GRID_Z = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [vgs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [31:0]                      cfg_data_i,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             mode_i,
  input  wire logic signed [31:0]               pos_x_i,
  input  wire logic signed [31:0]               pos_y_i,
  input  wire logic signed [31:0]               pos_z_i,
  input  wire logic signed [31:0]               store_value_i,
  output logic                                  done_o,
  output logic signed [31:0]                    cell_value_o,
  output logic                                  in_bounds_o,
  output logic [vgs_pkg::ADDR_W-1:0]            cell_index_o
);

  import vgs_pkg::*;

  localparam int unsigned XW     = $clog2(GRID_X);
  localparam int unsigned YW     = $clog2(GRID_Y);
  localparam int unsigned ZW     = $clog2(GRID_Z);
  localparam int unsigned GRID_W = $clog2(GRID_X * GRID_Y * GRID_Z);
  localparam int unsigned LIN_W  = (GRID_W > ADDR_W + 1) ? GRID_W : ADDR_W + 1;

  vgs_state_e        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  logic signed [31:0] min_x_q, min_y_q, min_z_q;
  logic        [31:0] scale_x_q, scale_y_q, scale_z_q;

  logic              mode_q;
  logic [DATA_W-1:0] value_q;
  logic              ok_q;
  logic [ADDR_W-1:0] idx_q;

  logic              done_q;
  logic [DATA_W-1:0] cell_value_q;
  logic              in_bounds_q;
  logic [ADDR_W-1:0] cell_index_q;

  logic              accept;
  axis_ctl_t         axis_ctl;
  logic              ok_x, ok_y, ok_z;
  logic [XW-1:0]     cell_x;
  logic [YW-1:0]     cell_y;
  logic [ZW-1:0]     cell_z;
  logic [LIN_W-1:0]  lin;
  logic              ok_all;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  assign accept          = start && !busy;
  assign busy            = (state_q != ST_IDLE);
  assign axis_ctl.sub_en = accept;
  assign axis_ctl.mul_en = (state_q == ST_MUL);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q   <= '0;
      min_y_q   <= '0;
      min_z_q   <= '0;
      scale_x_q <= 32'd65536;
      scale_y_q <= 32'd65536;
      scale_z_q <= 32'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_X:   min_x_q   <= cfg_data_i;
        CFG_MIN_Y:   min_y_q   <= cfg_data_i;
        CFG_MIN_Z:   min_z_q   <= cfg_data_i;
        CFG_SCALE_X: scale_x_q <= cfg_data_i;
        CFG_SCALE_Y: scale_y_q <= cfg_data_i;
        CFG_SCALE_Z: scale_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // axis lanes
  vgs_axis #(.COUNT(GRID_X)) u_axis_x (
    .clk_i, .ctl_i(axis_ctl), .pos_i(pos_x_i), .min_i(min_x_q),
    .scale_i(scale_x_q), .ok_o(ok_x), .cell_o(cell_x)
  );

  vgs_axis #(.COUNT(GRID_Y)) u_axis_y (
    .clk_i, .ctl_i(axis_ctl), .pos_i(pos_y_i), .min_i(min_y_q),
    .scale_i(scale_y_q), .ok_o(ok_y), .cell_o(cell_y)
  );

  vgs_axis #(.COUNT(GRID_Z)) u_axis_z (
    .clk_i, .ctl_i(axis_ctl), .pos_i(pos_z_i), .min_i(min_z_q),
    .scale_i(scale_z_q), .ok_o(ok_z), .cell_o(cell_z)
  );

  // x-fastest linear index and store capacity check
  assign lin = LIN_W'(cell_z) * LIN_W'(GRID_X * GRID_Y)
             + LIN_W'(cell_y) * LIN_W'(GRID_X)
             + LIN_W'(cell_x);
  assign ok_all = ok_x && ok_y && ok_z && (lin < LIN_W'(STORE_DEPTH));

  // item payload captured at accept, index and bounds flag in the index state
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      value_q <= store_value_i;
    end
    if (state_q == ST_IDX) begin
      ok_q  <= ok_all;
      idx_q <= lin[ADDR_W-1:0];
    end
  end

  // ram port: clearing pass or item access
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = lin[ADDR_W-1:0];
    ram_wdata = value_q;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_q;
      ram_wdata = EMPTY_VALUE;
    end else if (state_q == ST_IDX) begin
      ram_we = ok_all && (mode_q == MODE_WRITE);
    end
  end

  vgs_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_ram (
    .clk_i,
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_IDX;
      ST_IDX:  state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= (state_q == ST_RESP);
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESP) begin
      in_bounds_q  <= ok_q;
      cell_index_q <= ok_q ? idx_q : '0;
      if (!ok_q) begin
        cell_value_q <= EMPTY_VALUE;
      end else if (mode_q == MODE_WRITE) begin
        cell_value_q <= value_q;
      end else begin
        cell_value_q <= ram_rdata;
      end
    end
  end

  assign done_o       = done_q;
  assign cell_value_o = cell_value_q;
  assign in_bounds_o  = in_bounds_q;
  assign cell_index_o = cell_index_q;

endmodule

`default_nettype wire

>>> hw/rtl/vgs_checker.sv
// vgs_checker: port-level assertions for the voxel grid store
// uses vgs_pkg; bound to voxel_grid_store below
`default_nettype none

module vgs_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_we_i,
  input wire logic [vgs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input wire logic [31:0]                   cfg_data_i,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          mode_i,
  input wire logic signed [31:0]            pos_x_i,
  input wire logic signed [31:0]            pos_y_i,
  input wire logic signed [31:0]            pos_z_i,
  input wire logic signed [31:0]            store_value_i,
  input wire logic                          done_o,
  input wire logic signed [31:0]            cell_value_o,
  input wire logic                          in_bounds_o,
  input wire logic [vgs_pkg::ADDR_W-1:0]    cell_index_o
);

  import vgs_pkg::*;

  // an accepted item gives its result once the sequencer has passed mul, idx and resp
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##4 done_o)
    else $error("result not delivered four cycles after accept");

  // accepting an item makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // a result comes with the block ready again, one item at a time
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && !$past(done_o))
    else $error("result strobe while busy or repeated");

  // out-of-bounds results carry the empty value and index zero
  a_oob_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !in_bounds_o |-> (cell_value_o == EMPTY_VALUE) && (cell_index_o == '0))
    else $error("out-of-bounds result fields wrong");

endmodule

bind voxel_grid_store vgs_checker u_vgs_checker (.*);

`default_nettype wire
